// ===== design/owrb_pkg.sv =====
// ---------------------------------------------------------------------------
// owrb_pkg: shared types and constants for the overwrite ring store
// Request codes, the internal command word, record layout and the
// configuration register set used by every module of the block.
// ---------------------------------------------------------------------------
package owrb_pkg;

	localparam int TS_W     = 32;
	localparam int SMP_W    = 32;
	localparam int MV_W     = 16;
	localparam int DROP_W   = 32;
	localparam int BUDGET_W = 2;
	localparam int THR_W    = 12;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_NORMAL  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOOSTED = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESH  = 2'd2;

	localparam logic [BUDGET_W-1:0] NORMAL_RST  = 2'd1;
	localparam logic [BUDGET_W-1:0] BOOSTED_RST = 2'd2;
	localparam logic [THR_W-1:0]    THRESH_RST  = 12'd50;
	localparam logic [BUDGET_W-1:0] BUDGET_MAX  = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_DRAIN,
		OP_CLEAR
	} cmd_op_t;

	typedef struct packed {
		logic [TS_W-1:0]  ts;
		logic [SMP_W-1:0] smp;
		logic [MV_W-1:0]  mv;
	} rec_t;

	typedef struct packed {
		cmd_op_t op;
		rec_t    rec;
		logic    link_ready;
	} cmd_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] normal_batches;
		logic [BUDGET_W-1:0] boosted_batches;
		logic [THR_W-1:0]    boost_threshold;
	} cfg_t;

	typedef struct packed {
		logic              batch_end;
		logic              pass_end;
		logic [DROP_W-1:0] dropped;
	} meta_t;

endpackage

// ===== design/owrb_req_if.sv =====
// ---------------------------------------------------------------------------
// owrb_req_if: request channel
// Valid/ready channel carrying one request word with its record fields.
// ---------------------------------------------------------------------------
interface owrb_req_if import owrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TS_W-1:0]   in_timestamp;
	logic [SMP_W-1:0]  in_sample;
	logic [MV_W-1:0]   in_battery_mv;
	logic              link_ready;

	modport source (
		output valid, req_type, in_timestamp, in_sample, in_battery_mv, link_ready,
		input  ready
	);
	modport sink (
		input  valid, req_type, in_timestamp, in_sample, in_battery_mv, link_ready,
		output ready
	);
endinterface

// ===== design/owrb_rsp_if.sv =====
// ---------------------------------------------------------------------------
// owrb_rsp_if: drained record channel
// Valid/ready channel carrying one drained record word with its markers.
// ---------------------------------------------------------------------------
interface owrb_rsp_if import owrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TS_W-1:0]   out_timestamp;
	logic [SMP_W-1:0]  out_sample;
	logic [MV_W-1:0]   out_battery_mv;
	logic              batch_end;
	logic              pass_end;
	logic [DROP_W-1:0] dropped_total;

	modport source (
		output valid, out_timestamp, out_sample, out_battery_mv, batch_end, pass_end,
			dropped_total,
		input  ready
	);
	modport sink (
		input  valid, out_timestamp, out_sample, out_battery_mv, batch_end, pass_end,
			dropped_total,
		output ready
	);
endinterface

// ===== design/owrb_front.sv =====
// ---------------------------------------------------------------------------
// owrb_front: request intake
// Accepts request words, decodes them into commands and drops unused codes.
// ---------------------------------------------------------------------------
module owrb_front import owrb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	owrb_req_if.sink    req,
	output logic        cmd_vld,
	output cmd_t        cmd,
	input  logic        cmd_rdy
);

	logic    vld_s1;
	cmd_t    cmd_s1;
	logic    take;
	logic    known;
	cmd_op_t op;

	assign req.ready = !vld_s1 || cmd_rdy;
	assign take      = req.valid && req.ready;
	assign cmd_vld   = vld_s1;
	assign cmd       = cmd_s1;

	always_comb begin
		op    = OP_PUSH;
		known = 1'b1;
		unique case (req.req_type)
			REQ_PUSH:  op = OP_PUSH;
			REQ_DRAIN: op = OP_DRAIN;
			REQ_CLEAR: op = OP_CLEAR;
			default:   known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= known;
		end else if (cmd_rdy) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op         <= op;
			cmd_s1.rec.ts     <= req.in_timestamp;
			cmd_s1.rec.smp    <= req.in_sample;
			cmd_s1.rec.mv     <= req.in_battery_mv;
			cmd_s1.link_ready <= req.link_ready;
		end
	end

endmodule

// ===== design/owrb_queue.sv =====
// ---------------------------------------------------------------------------
// owrb_queue: command queue
// Short first-in first-out buffer between the intake and the executor.
// ---------------------------------------------------------------------------
module owrb_queue import owrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_vld,
	input  cmd_t push_cmd,
	output logic push_rdy,
	output logic pop_vld,
	output cmd_t pop_cmd,
	input  logic pop_rdy
);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_rdy = cnt_q != QCW'(QDEPTH);
	assign pop_vld  = cnt_q != '0;
	assign pop_cmd  = slot_q[rd_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(do_push) - QCW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/owrb_back.sv =====
// ---------------------------------------------------------------------------
// owrb_back: record store and drain sequencer
// Holds the ring memory and pointers, executes push, clear and drain
// commands, and buffers drained records in a two-word output stage.
// ---------------------------------------------------------------------------
module owrb_back import owrb_pkg::*; #(
	parameter int STORE_DEPTH = 2048,
	parameter int BATCH_LEN   = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cmd_vld,
	input  cmd_t        cmd,
	output logic        cmd_rdy,
	owrb_rsp_if.source  rsp
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);
	localparam int IW = (BATCH_LEN > 1) ? $clog2(BATCH_LEN) : 1;
	localparam int CW = (FW > THR_W) ? FW : THR_W;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	rec_t                mem [STORE_DEPTH];
	logic [PW-1:0]       wp_q;
	logic [PW-1:0]       rp_q;
	logic [PW-1:0]       wp_nxt;
	logic [PW-1:0]       rp_nxt;
	logic [FW-1:0]       fill_q;
	logic [DROP_W-1:0]   drop_q;
	logic [BUDGET_W-1:0] rem_q;
	logic [IW-1:0]       idx_q;

	rec_t                rec_s1;
	meta_t               meta_s1;
	logic                vld_s1;

	rec_t                orec_q [2];
	meta_t               ometa_q [2];
	logic                owr_q;
	logic                ord_q;
	logic [1:0]          ocnt_q;

	logic                pop;
	logic                issue;
	logic                last_rec;
	logic                more;
	logic                full;
	logic                boost;
	logic                start;
	logic                push_wr;
	logic [BUDGET_W-1:0] budget;

	assign wp_nxt   = (wp_q == PW'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nxt   = (rp_q == PW'(STORE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign full     = fill_q == FW'(STORE_DEPTH);
	assign boost    = CW'(fill_q) >= CW'(cfg.boost_threshold);

	always_comb begin
		budget = boost ? cfg.boosted_batches : cfg.normal_batches;
		if (budget > BUDGET_MAX) begin
			budget = BUDGET_MAX;
		end
	end

	assign start    = (budget != '0) && cmd.link_ready && (fill_q >= FW'(BATCH_LEN));
	assign cmd_rdy  = state_q == ST_IDLE;
	assign push_wr  = (state_q == ST_IDLE) && cmd_vld && (cmd.op == OP_PUSH);
	assign pop      = rsp.valid && rsp.ready;

	// A read is issued only when the output stage plus the word in flight
	// leave room for it after this cycle's pop.
	assign issue    = (state_q == ST_DRAIN) && ((ocnt_q + 2'(vld_s1)) <= (2'd1 + 2'(pop)));
	assign last_rec = idx_q == IW'(BATCH_LEN - 1);
	// A second batch follows only if the budget allows it and a full batch
	// remains once this record is consumed.
	assign more     = (rem_q == BUDGET_MAX) && (fill_q > FW'(BATCH_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			fill_q  <= '0;
			drop_q  <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			vld_s1 <= issue;
			ocnt_q <= ocnt_q + 2'(vld_s1) - 2'(pop);
			if (vld_s1) begin
				owr_q <= ~owr_q;
			end
			if (pop) begin
				ord_q <= ~ord_q;
			end
			unique case (state_q)
				ST_IDLE: if (cmd_vld) begin
					unique case (cmd.op)
						OP_PUSH: begin
							wp_q <= wp_nxt;
							if (full) begin
								rp_q   <= rp_nxt;
								drop_q <= drop_q + 1'b1;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
						OP_DRAIN: if (start) begin
							state_q <= ST_DRAIN;
							rem_q   <= budget;
							idx_q   <= '0;
						end
						OP_CLEAR: begin
							wp_q   <= '0;
							rp_q   <= '0;
							fill_q <= '0;
						end
						default: ;
					endcase
				end
				ST_DRAIN: if (issue) begin
					rp_q   <= rp_nxt;
					fill_q <= fill_q - 1'b1;
					if (last_rec) begin
						idx_q <= '0;
						if (more) begin
							rem_q <= rem_q - 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_wr) begin
			mem[wp_q] <= cmd.rec;
		end
		if (issue) begin
			rec_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1.batch_end <= last_rec;
			meta_s1.pass_end  <= last_rec && !more;
			meta_s1.dropped   <= drop_q;
		end
		if (vld_s1) begin
			orec_q[owr_q]  <= rec_s1;
			ometa_q[owr_q] <= meta_s1;
		end
	end

	assign rsp.valid          = ocnt_q != '0;
	assign rsp.out_timestamp  = orec_q[ord_q].ts;
	assign rsp.out_sample     = orec_q[ord_q].smp;
	assign rsp.out_battery_mv = orec_q[ord_q].mv;
	assign rsp.batch_end      = ometa_q[ord_q].batch_end;
	assign rsp.pass_end       = ometa_q[ord_q].pass_end;
	assign rsp.dropped_total  = ometa_q[ord_q].dropped;

endmodule

// ===== design/overwrite_ring_batch_drain.sv =====
// Push and clear complete without leaving the executor's idle state; a started drain
// reads records into a read register and then the output stage, one per cycle while
// the output stage has room. A pass holds the executor for up to BUDGET_MAX batches.
// Commands queue ahead of the executor, so intake runs in a pass until the queue fills.
// Reset clears pointers, fill level, drop counter and queues and loads register
// defaults; the record memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// overwrite_ring_batch_drain: overwrite-oldest record store with batch drain
// Top level: configuration registers, request intake, command queue and
// the store executor.
// ---------------------------------------------------------------------------
module overwrite_ring_batch_drain import owrb_pkg::*; #(
	parameter int STORE_DEPTH = 2048,
	parameter int BATCH_LEN   = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	owrb_req_if.sink          req,
	owrb_rsp_if.source        rsp
);

	cfg_t                 cfg_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 f_vld;
	cmd_t                 f_cmd;
	logic                 f_rdy;
	logic                 q_vld;
	cmd_t                 q_cmd;
	logic                 q_rdy;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_batches  <= NORMAL_RST;
			cfg_q.boosted_batches <= BOOSTED_RST;
			cfg_q.boost_threshold <= THRESH_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NORMAL:  cfg_q.normal_batches  <= pwdata[BUDGET_W-1:0];
				REG_BOOSTED: cfg_q.boosted_batches <= pwdata[BUDGET_W-1:0];
				REG_THRESH:  cfg_q.boost_threshold <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NORMAL:  prdata = APB_DW'(cfg_q.normal_batches);
			REG_BOOSTED: prdata = APB_DW'(cfg_q.boosted_batches);
			REG_THRESH:  prdata = APB_DW'(cfg_q.boost_threshold);
			default:     prdata = '0;
		endcase
	end

	owrb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cmd_vld (f_vld),
		.cmd     (f_cmd),
		.cmd_rdy (f_rdy)
	);

	owrb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (f_vld),
		.push_cmd (f_cmd),
		.push_rdy (f_rdy),
		.pop_vld  (q_vld),
		.pop_cmd  (q_cmd),
		.pop_rdy  (q_rdy)
	);

	owrb_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.BATCH_LEN   (BATCH_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd_vld (q_vld),
		.cmd     (q_cmd),
		.cmd_rdy (q_rdy),
		.rsp     (rsp)
	);

	// The last word of a pass always closes a batch.
	a_pass_end_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.pass_end |-> rsp.batch_end)
		else $error("pass end without batch end");

	// Within one pass every word carries the same drop count.
	a_drop_stable_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.pass_end
		|=> !rsp.valid || rsp.dropped_total == $past(rsp.dropped_total))
		else $error("drop count changed inside a pass");

	a_thresh_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && reg_idx == REG_THRESH
		|=> cfg_q.boost_threshold == $past(pwdata[THR_W-1:0]))
		else $error("threshold register write lost");

endmodule
